// ----- rtl/rate_limited_slot_pool_with_expiry_macros.svh -----
`ifndef RATE_LIMITED_SLOT_POOL_WITH_EXPIRY_MACROS_SVH
`define RATE_LIMITED_SLOT_POOL_WITH_EXPIRY_MACROS_SVH

// same-cycle implication
`define RLSP_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rlsp check failed");

// next-cycle implication
`define RLSP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rlsp check failed");

`endif

// ----- rtl/rlsp_pkg.sv -----
`default_nettype none
package rlsp_pkg;

  localparam int SLOTS      = 64;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W      = $clog2(SLOTS + 1);
  localparam int CNT_W      = PTR_W;
  localparam int TIME_W     = 32;
  localparam int RATE_W     = 32;
  localparam int CREDIT_W   = 48;
  localparam int PROD_W     = 64;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int SLOT_OUT_W = 6;
  localparam int CNT_OUT_W  = 7;

  localparam logic [CFG_IDX_W-1:0] REG_CREDIT_RATE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIFE_TICKS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EMITS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_ENABLE = 8'd3;

  localparam logic [CREDIT_W-1:0] ONE_CREDIT = 48'h0000_0001_0000;
  localparam logic [CREDIT_W-1:0] TWO_CREDIT = 48'h0000_0002_0000;
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic start;
    logic exp_step;
    logic credit_add;
    logic claim_step;
    logic out_init;
    logic out_step;
  } cmd_t;

  typedef struct packed {
    logic exp_done;
    logic claim_done;
    logic out_done;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/rlsp_ctrl.sv -----
`default_nettype none
module rlsp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rlsp_pkg::status_t status,
  output rlsp_pkg::cmd_t        cmd
);
  import rlsp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXPIRE = 5'b00010,
    S_CREDIT = 5'b00100,
    S_CLAIM  = 5'b01000,
    S_OUTPUT = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !rst) begin
          cmd.start  = 1'b1;
          state_next = S_EXPIRE;
        end
      end
      S_EXPIRE: begin
        cmd.exp_step = 1'b1;
        if (status.exp_done) state_next = S_CREDIT;
      end
      S_CREDIT: begin
        cmd.credit_add = 1'b1;
        state_next     = S_CLAIM;
      end
      S_CLAIM: begin
        cmd.claim_step = 1'b1;
        if (status.claim_done) begin
          cmd.out_init = 1'b1;
          state_next   = S_OUTPUT;
        end
      end
      S_OUTPUT: begin
        cmd.out_step = 1'b1;
        if (status.out_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

// ----- rtl/rlsp_dpath.sv -----
`default_nettype none
module rlsp_dpath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rlsp_pkg::cmd_t                 cmd,
  output rlsp_pkg::status_t                   status,
  input  wire logic [rlsp_pkg::TIME_W-1:0]    now_ticks,
  input  wire logic                           cfg_we,
  input  wire logic [rlsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rlsp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           out_stall,
  output logic                                out_valid,
  output logic [rlsp_pkg::SLOT_OUT_W-1:0]     slot_index,
  output logic                                claimed,
  output logic                                is_last,
  output logic [rlsp_pkg::CNT_OUT_W-1:0]      live_slots,
  output logic [rlsp_pkg::CNT_OUT_W-1:0]      expired_slots,
  output logic                                pool_overflow
);
  import rlsp_pkg::*;

  // configuration
  logic [RATE_W-1:0] credit_rate;
  logic [TIME_W-1:0] life_ticks;
  logic [31:0]       max_total_emits;
  logic              emit_enable;

  // tick state
  logic [TIME_W-1:0]   prev_time;
  logic [TIME_W-1:0]   now_reg;
  logic [TIME_W-1:0]   delta;
  logic [PROD_W-1:0]   product;
  logic [CREDIT_W-1:0] credit;
  logic [31:0]         total;
  logic [SLOTS-1:0]    alive;
  logic [SLOTS-1:0]    mask;
  logic [CNT_W-1:0]    live_cnt;
  logic [CNT_W-1:0]    exp_cnt;
  logic [CNT_W-1:0]    nclaims;
  logic [CNT_W-1:0]    out_cnt;
  logic                overflow;
  logic                claim_stop;
  logic [PTR_W-1:0]    ptr;
  logic                rd_vld;
  logic [IDX_W-1:0]    rd_idx;
  logic [TIME_W-1:0]   rd_data;

  logic [TIME_W-1:0] birth_mem [SLOTS];

  logic [IDX_W-1:0]  pidx;
  logic              ptr_end;
  logic              gt_one, gt_two, cap_hit;
  logic              claim_done, claim_go, claim_take;
  logic              exp_issue, exp_hit;
  logic              out_free, out_done, out_go, ptr_bit, out_load;
  logic [CNT_W-1:0]  out_total;
  logic [PROD_W:0]   credit_sum;
  logic [CREDIT_W-1:0] credit_collapse;
  logic [IDX_W+SLOT_OUT_W-1:0] idx_ext;
  logic [CNT_W+CNT_OUT_W-1:0]  live_ext, exp_ext;

  assign pidx    = ptr[IDX_W-1:0];
  assign ptr_end = (ptr == PTR_W'(SLOTS));

  assign gt_one  = credit > ONE_CREDIT;
  assign gt_two  = credit > TWO_CREDIT;
  assign cap_hit = (max_total_emits != 32'd0) && (total >= max_total_emits);

  assign claim_done = claim_stop || !gt_one || cap_hit;
  assign claim_go   = cmd.claim_step && !claim_done;
  assign claim_take = claim_go && !ptr_end && !alive[pidx] && emit_enable;

  assign exp_issue = cmd.exp_step && !ptr_end;
  assign exp_hit   = cmd.exp_step && rd_vld && alive[rd_idx] &&
                     ((now_reg - rd_data) > life_ticks);

  assign credit_sum = {{(PROD_W + 1 - CREDIT_W){1'b0}}, credit} + {1'b0, product};
  // low part of (credit - 1.0 - 1) plus one lands in (0, 1.0]
  assign credit_collapse = {{(CREDIT_W - 16){1'b0}}, credit[15:0] - 16'd1} +
                           CREDIT_W'(1);

  assign out_free  = !out_valid || !out_stall;
  assign out_total = (nclaims == '0) ? CNT_W'(1) : nclaims;
  assign out_done  = (out_cnt == out_total);
  assign out_go    = cmd.out_step && !out_done;
  assign ptr_bit   = !ptr_end && mask[pidx];
  assign out_load  = out_go && out_free && ((nclaims == '0) || ptr_bit);

  assign status.exp_done   = ptr_end && !rd_vld;
  assign status.claim_done = claim_done;
  assign status.out_done   = out_done;

  assign idx_ext  = {{SLOT_OUT_W{1'b0}}, pidx};
  assign live_ext = {{CNT_OUT_W{1'b0}}, live_cnt};
  assign exp_ext  = {{CNT_OUT_W{1'b0}}, exp_cnt};

  // birth time store, one port shared by the expiry scan and the claim pass
  always_ff @(posedge clk) begin
    if (claim_take) birth_mem[pidx] <= now_reg;
    rd_data <= birth_mem[pidx];
  end

  always_ff @(posedge clk) begin
    product <= {{(PROD_W - TIME_W){1'b0}}, delta} * {{(PROD_W - RATE_W){1'b0}}, credit_rate};
    if (cmd.start) begin
      now_reg <= now_ticks;
      delta   <= now_ticks - prev_time;
    end
    if (cmd.exp_step) rd_idx <= pidx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_rate     <= '0;
      life_ticks      <= '0;
      max_total_emits <= '0;
      emit_enable     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CREDIT_RATE: credit_rate     <= cfg_data;
        REG_LIFE_TICKS:  life_ticks      <= cfg_data;
        REG_MAX_EMITS:   max_total_emits <= cfg_data;
        REG_EMIT_ENABLE: emit_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time  <= '0;
      credit     <= '0;
      total      <= '0;
      alive      <= '0;
      mask       <= '0;
      live_cnt   <= '0;
      exp_cnt    <= '0;
      nclaims    <= '0;
      out_cnt    <= '0;
      overflow   <= 1'b0;
      claim_stop <= 1'b0;
      ptr        <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      if (cmd.start) begin
        prev_time  <= now_ticks;
        mask       <= '0;
        exp_cnt    <= '0;
        nclaims    <= '0;
        overflow   <= 1'b0;
        claim_stop <= 1'b0;
        ptr        <= '0;
        rd_vld     <= 1'b0;
      end

      if (cmd.exp_step) begin
        rd_vld <= exp_issue;
        if (exp_issue) ptr <= ptr + PTR_W'(1);
        if (exp_hit) begin
          alive[rd_idx] <= 1'b0;
          exp_cnt       <= exp_cnt + CNT_W'(1);
          live_cnt      <= live_cnt - CNT_W'(1);
        end
      end

      if (cmd.credit_add) begin
        credit <= (|credit_sum[PROD_W:CREDIT_W]) ? CREDIT_MAX : credit_sum[CREDIT_W-1:0];
        ptr    <= '0;
      end

      if (claim_go) begin
        if (ptr_end) begin
          // no free slot left: this credit is lost
          credit     <= credit - ONE_CREDIT;
          overflow   <= 1'b1;
          claim_stop <= 1'b1;
        end else if (alive[pidx]) begin
          ptr <= ptr + PTR_W'(1);
        end else if (emit_enable) begin
          credit        <= credit - ONE_CREDIT;
          alive[pidx]   <= 1'b1;
          mask[pidx]    <= 1'b1;
          live_cnt      <= live_cnt + CNT_W'(1);
          nclaims       <= nclaims + CNT_W'(1);
          ptr           <= ptr + PTR_W'(1);
          if (total != 32'hFFFF_FFFF) total <= total + 32'd1;
        end else begin
          // disabled: the whole countdown finishes in one step
          credit     <= gt_two ? credit_collapse : (credit - ONE_CREDIT);
          claim_stop <= 1'b1;
        end
      end

      if (cmd.out_init) begin
        ptr     <= '0;
        out_cnt <= '0;
      end

      if (out_load) begin
        out_cnt <= out_cnt + CNT_W'(1);
        if (nclaims != '0) ptr <= ptr + PTR_W'(1);
      end else if (out_go && (nclaims != '0) && !ptr_bit) begin
        ptr <= ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot_index    <= (nclaims == '0) ? '0 : idx_ext[SLOT_OUT_W-1:0];
      claimed       <= (nclaims != '0);
      is_last       <= (nclaims == '0) || ((out_cnt + CNT_W'(1)) == nclaims);
      live_slots    <= live_ext[CNT_OUT_W-1:0];
      expired_slots <= exp_ext[CNT_OUT_W-1:0];
      pool_overflow <= overflow;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rate_limited_slot_pool_with_expiry.sv -----
`default_nettype none
// channel   direction  handshake              beat contents
// in        sink       in_valid / in_stall    now_ticks
// out       source     out_valid / out_stall  slot_index claimed is_last live_slots
//                                             expired_slots pool_overflow
// cfg       sink       cfg_valid / cfg_ready  cfg_index cfg_data
//
// a taken tick holds in_stall through the expiry scan of the birth time ram, the credit add,
// the claim pass and the result pass, and longer while the output stalls; beats leave at
// most one per cycle from one output register
// the next tick is taken once the last beat is loaded, even if it still waits
// rst is synchronous: pool empty, credit, time and counters zero, emitting enabled
// in_stall is high and cfg_ready low while rst is high
module rate_limited_slot_pool_with_expiry (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rlsp_pkg::TIME_W-1:0]    now_ticks,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [rlsp_pkg::SLOT_OUT_W-1:0]     slot_index,
  output logic                                claimed,
  output logic                                is_last,
  output logic [rlsp_pkg::CNT_OUT_W-1:0]      live_slots,
  output logic [rlsp_pkg::CNT_OUT_W-1:0]      expired_slots,
  output logic                                pool_overflow,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rlsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rlsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rlsp_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = !rst;

  rlsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rlsp_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .now_ticks     (now_ticks),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .slot_index    (slot_index),
    .claimed       (claimed),
    .is_last       (is_last),
    .live_slots    (live_slots),
    .expired_slots (expired_slots),
    .pool_overflow (pool_overflow)
  );

endmodule
`default_nettype wire

// ----- rtl/rlsp_checker.sv -----
`default_nettype none
`include "rate_limited_slot_pool_with_expiry_macros.svh"
module rlsp_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [rlsp_pkg::SLOT_OUT_W-1:0] slot_index,
  input wire logic                           claimed,
  input wire logic                           is_last,
  input wire logic [rlsp_pkg::CNT_OUT_W-1:0] live_slots,
  input wire logic [rlsp_pkg::CNT_OUT_W-1:0] expired_slots,
  input wire logic                           pool_overflow
);
  import rlsp_pkg::*;

  logic [SLOT_OUT_W+2*CNT_OUT_W+2:0] out_word;

  assign out_word = {slot_index, claimed, is_last, live_slots, expired_slots, pool_overflow};

  // a tick with no claim gives a single closing beat
  `RLSP_ASSERT_NOW(a_noclaim_last, clk, rst, out_valid && !claimed, is_last && (slot_index == '0))

  // the pool never reports more live or freed slots than it has
  `RLSP_ASSERT_NOW(a_live_bound, clk, rst, out_valid, live_slots <= SLOTS)

  `RLSP_ASSERT_NOW(a_expired_bound, clk, rst, out_valid, expired_slots <= SLOTS)

  // a taken tick keeps the block busy on the next cycle
  `RLSP_ASSERT_NEXT(a_busy_after_tick, clk, rst, in_valid && !in_stall, in_stall)

  // a stalled result beat holds
  `RLSP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind rate_limited_slot_pool_with_expiry rlsp_checker u_rlsp_checker (.*);
`default_nettype wire

// ----- verif/rate_limited_slot_pool_with_expiry_tb.sv -----
`default_nettype none
module rate_limited_slot_pool_with_expiry_tb;
  import rlsp_pkg::*;

  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int PHASE_TICKS    = 25;
  localparam int IDLE_PCT       = 23;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [TIME_W-1:0]       now_ticks;
  logic                    out_valid;
  logic                    out_stall;
  logic [SLOT_OUT_W-1:0]   slot_index;
  logic                    claimed;
  logic                    is_last;
  logic [CNT_OUT_W-1:0]    live_slots;
  logic [CNT_OUT_W-1:0]    expired_slots;
  logic                    pool_overflow;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  typedef struct {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  claimed;
    logic                  last;
    logic [CNT_OUT_W-1:0]  live;
    logic [CNT_OUT_W-1:0]  expired;
    logic                  overflow;
  } pool_beat_t;

  pool_beat_t pending_beats[$];
  int   error_count  = 0;
  int   quiet_cycles = 0;
  logic no_idle      = 1'b0;
  logic hold_req     = 1'b0;
  logic [TIME_W-1:0] tick_time = '0;

  // shadow of the pool
  logic [RATE_W-1:0]   rate_m    = '0;
  logic [TIME_W-1:0]   life_m    = '0;
  logic [31:0]         cap_m     = '0;
  logic                enable_m  = 1'b1;
  logic [SLOTS-1:0]    live_m    = '0;
  logic [TIME_W-1:0]   birth_m [SLOTS];
  logic [CREDIT_W-1:0] credit_m  = '0;
  logic [TIME_W-1:0]   prev_time_m = '0;
  logic [31:0]         emitted_m = '0;

  rate_limited_slot_pool_with_expiry DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .now_ticks     (now_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .slot_index    (slot_index),
    .claimed       (claimed),
    .is_last       (is_last),
    .live_slots    (live_slots),
    .expired_slots (expired_slots),
    .pool_overflow (pool_overflow),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void predict_tick(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       gain;
    logic [63:0]       credit;
    logic              ovf;
    int                pos;
    int                n_expired;
    int                picks[$];
    pool_beat_t        beat;
    elapsed     = t - prev_time_m;
    prev_time_m = t;
    n_expired   = 0;
    ovf         = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (live_m[i] && (t - birth_m[i]) > life_m) begin
        live_m[i] = 1'b0;
        n_expired++;
      end
    end
    gain   = 64'(elapsed) * 64'(rate_m);
    credit = 64'(credit_m);
    if (gain > 64'(CREDIT_MAX) - credit) credit = 64'(CREDIT_MAX);
    else credit = credit + gain;
    while (credit > 64'(ONE_CREDIT)) begin
      if (cap_m != 0 && emitted_m >= cap_m) break;
      credit = credit - 64'(ONE_CREDIT);
      pos = -1;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!live_m[i]) pos = i;
      if (pos < 0) begin
        ovf = 1'b1;
        break;
      end
      if (!enable_m) begin
        // nothing changes per pass, so credit drops to its last fraction at once
        if (credit > 64'(ONE_CREDIT))
          credit = ((credit - 1) & (64'(ONE_CREDIT) - 1)) + 1;
        continue;
      end
      live_m[pos]  = 1'b1;
      birth_m[pos] = t;
      if (emitted_m != '1) emitted_m++;
      picks.push_back(pos);
    end
    credit_m = credit[CREDIT_W-1:0];

    beat.claimed  = (picks.size() > 0);
    beat.live     = CNT_OUT_W'($countones(live_m));
    beat.expired  = CNT_OUT_W'(n_expired);
    beat.overflow = ovf;
    if (picks.size() == 0) begin
      beat.slot = '0;
      beat.last = 1'b1;
      pending_beats.push_back(beat);
    end
    foreach (picks[k]) begin
      beat.slot = SLOT_OUT_W'(picks[k]);
      beat.last = (k == picks.size() - 1);
      pending_beats.push_back(beat);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    pool_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: slot_index %0d", slot_index);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        check_field("slot_index", 32'(want.slot), 32'(slot_index));
        check_field("claimed", 32'(want.claimed), 32'(claimed));
        check_field("is_last", 32'(want.last), 32'(is_last));
        check_field("live_slots", 32'(want.live), 32'(live_slots));
        check_field("expired_slots", 32'(want.expired), 32'(expired_slots));
        check_field("pool_overflow", 32'(want.overflow), 32'(pool_overflow));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic offer_tick(input logic [TIME_W-1:0] t);
    int gap;
    gap = 0;
    // gaps up to a whole tick so they land on every part of the pass
    if (!no_idle && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(3 * SLOTS, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    now_ticks <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tick(t);
    tick_time = t;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CREDIT_RATE: rate_m   = val;
      REG_LIFE_TICKS:  life_m   = val;
      REG_MAX_EMITS:   cap_m    = val;
      REG_EMIT_ENABLE: enable_m = val[0];
      default: ;
    endcase
  endtask

  // every setting ends with a write to an unused index, which must be ignored
  task automatic set_config(input logic [31:0] rate, input logic [31:0] life,
                            input logic [31:0] cap, input logic [31:0] en_word);
    write_reg(REG_CREDIT_RATE, rate);
    write_reg(REG_LIFE_TICKS, life);
    write_reg(REG_MAX_EMITS, cap);
    write_reg(REG_EMIT_ENABLE, en_word);
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_EMIT_ENABLE + 1)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // empty the pool and burn off a large credit with emitting disabled
  task automatic flush_credit();
    set_config(32'd0, 32'd0, 32'd0, 32'd0);
    offer_tick(tick_time + 1);
    wait_idle();
  endtask

  task automatic run_phase(input int ticks);
    logic [31:0] rate;
    logic [31:0] life;
    logic [31:0] cap;
    logic [31:0] en_word;
    int          pick;
    if (credit_m > (ONE_CREDIT << 8)) flush_credit();
    pick = $urandom_range(9);
    rate = (pick == 0) ? 32'd0 : (pick == 1) ? '1 : (pick == 2) ? $urandom :
           $urandom_range(32'h0004_0000, 32'h0000_2000);
    pick = $urandom_range(9);
    life = (pick == 0) ? 32'd0 : (pick == 1) ? '1 : (pick == 2) ? $urandom :
           $urandom_range(80, 1);
    pick = $urandom_range(9);
    cap  = (pick < 7) ? 32'd0 : (pick < 9) ? emitted_m + $urandom_range(40, 1) : $urandom;
    en_word    = $urandom;
    en_word[0] = ($urandom_range(9) != 0);
    set_config(rate, life, cap, en_word);
    repeat (ticks) begin
      pick = $urandom_range(39);
      if (pick == 0) offer_tick(tick_time);
      else if (pick == 1) offer_tick($urandom);
      else offer_tick(tick_time + $urandom_range(8, 1));
    end
    wait_idle();
  endtask

  // reset values: no rate, so every tick gives one empty beat
  task automatic test_reset_defaults();
    offer_tick(32'd0);
    offer_tick(32'd5);
    wait_idle();
  endtask

  // credit of exactly one must not claim; slots at the lifetime survive, one past expire
  task automatic test_claim_and_expiry();
    set_config(32'h0003_0000, 32'd4, 32'd0, 32'd1);
    offer_tick(32'd6);
    offer_tick(32'd7);
    offer_tick(32'd10);
    offer_tick(32'd11);
    wait_idle();
  endtask

  task automatic test_overflow_and_wrap();
    set_config('1, '1, 32'd0, 32'd1);
    offer_tick(32'hFFFF_FFF0);
    offer_tick(32'h0000_0010);
    wait_idle();
    // zero lifetime frees the whole pool, then it refills
    set_config('1, 32'd0, 32'd0, 32'd1);
    offer_tick(32'h0000_0011);
    wait_idle();
  endtask

  task automatic test_emit_cap();
    set_config(32'h0001_8000, 32'd2, emitted_m + 3, 32'd1);
    offer_tick(32'h20);
    offer_tick(32'h21);
    wait_idle();
  endtask

  task automatic test_emit_disabled();
    set_config(32'h0000_8000, 32'd2, 32'd0, 32'hFFFF_FFFE);
    offer_tick(32'h30);
    offer_tick(32'h31);
    wait_idle();
    set_config(32'h0000_8000, 32'd2, 32'd0, 32'h0000_0001);
    for (int i = 2; i < 7; i++) offer_tick(32'h30 + i);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    repeat (5) run_phase(PHASE_TICKS);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    run_phase(PHASE_TICKS);
    no_idle = 1'b0;
  endtask

  // receiver holds off while ticks keep coming, so the pool pass and input stall
  task automatic test_result_backpressure();
    hold_req = 1'b1;
    no_idle  = 1'b1;
    run_phase(PHASE_TICKS);
    no_idle  = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    now_ticks = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_claim_and_expiry();
    test_overflow_and_wrap();
    test_emit_cap();
    test_emit_disabled();
    test_random_traffic();
    test_back_to_back();
    test_result_backpressure();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ----- rate_limited_slot_pool_with_expiry.f -----
+incdir+rtl
rtl/rlsp_pkg.sv
rtl/rlsp_ctrl.sv
rtl/rlsp_dpath.sv
rtl/rate_limited_slot_pool_with_expiry.sv
rtl/rlsp_checker.sv
verif/rate_limited_slot_pool_with_expiry_tb.sv
